// ===== hdl/ipq_pkg.sv =====
// Package for the indexed pickable queue: transfer payload types, operation
// and status codes, link encoding and the memory request type.
// No dependencies.
package ipq_pkg;

	localparam int ID_W       = 10;
	localparam int NODE_COUNT = 1 << ID_W;
	localparam int LINK_W     = ID_W + 1;

	// A link with its top bit set is null; only this pattern is ever written as null.
	localparam logic [LINK_W-1:0] NIL_LINK = {LINK_W{1'b1}};

	localparam logic [2:0] FN_PICK      = 3'd0;
	localparam logic [2:0] FN_PUSH_HEAD = 3'd1;
	localparam logic [2:0] FN_PUSH_TAIL = 3'd2;
	localparam logic [2:0] FN_POP_HEAD  = 3'd3;
	localparam logic [2:0] FN_POP_TAIL  = 3'd4;

	localparam logic [1:0] STAT_DONE    = 2'd0;
	localparam logic [1:0] STAT_IGNORED = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;

	typedef struct packed {
		logic [2:0]      func;
		logic [ID_W-1:0] node_id;
	} ipq_in_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [ID_W-1:0] popped_node;
		logic            popped_valid;
		logic            now_empty;
	} ipq_out_t;

	typedef struct packed {
		logic              we;
		logic [ID_W-1:0]   waddr;
		logic [LINK_W-1:0] wdata;
		logic              re;
		logic [ID_W-1:0]   raddr;
	} ipq_mem_req_t;

	function automatic logic in_pool(input logic [LINK_W-1:0] l);
		return l < LINK_W'(NODE_COUNT);
	endfunction

endpackage

// ===== hdl/ipq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data between reads. No dependencies.
module ipq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ipq_ctrl.sv =====
// Sequencer of the indexed pickable queue: clearing pass, head and tail
// registers, and the read-modify-write of the two link memories.
// Depends on ipq_pkg.
module ipq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  ipq_pkg::ipq_in_t      req,
	output logic                  busy,
	output ipq_pkg::ipq_mem_req_t prev_req,
	output ipq_pkg::ipq_mem_req_t next_req,
	input  logic [ipq_pkg::LINK_W-1:0] prev_rdata,
	input  logic [ipq_pkg::LINK_W-1:0] next_rdata,
	output logic                  res_valid,
	input  logic                  res_ready,
	output ipq_pkg::ipq_out_t     res
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EXEC  = 2'd2;
	localparam logic [1:0] ST_WB    = 2'd3;

	logic [1:0]                 state_q;
	logic [ipq_pkg::ID_W-1:0]   clr_cnt_q;
	logic [ipq_pkg::LINK_W-1:0] head_q, tail_q;
	logic [2:0]                 func_s1;
	logic [ipq_pkg::LINK_W-1:0] node_s1;
	logic [1:0]                 status_s2;
	logic                       unlink_s2;
	logic                       pop_s2;

	logic                       accept;
	logic                       wb_go;
	logic                       clr_last;
	logic [ipq_pkg::LINK_W-1:0] p, n, x;
	logic                       is_pop;
	logic                       linked;
	logic [1:0]                 ex_status;
	logic                       ex_unlink;
	logic [ipq_pkg::LINK_W-1:0] head_d, tail_d;

	assign accept   = (state_q == ST_IDLE) && req_valid;
	assign wb_go    = (state_q == ST_WB) && res_ready;
	assign clr_last = clr_cnt_q == ipq_pkg::ID_W'(ipq_pkg::NODE_COUNT - 1);
	assign busy     = state_q != ST_IDLE;

	assign p      = prev_rdata;
	assign n      = next_rdata;
	assign x      = node_s1;
	assign is_pop = (func_s1 == ipq_pkg::FN_POP_HEAD) || (func_s1 == ipq_pkg::FN_POP_TAIL);
	assign linked = (p != ipq_pkg::NIL_LINK) || (n != ipq_pkg::NIL_LINK) ||
	                (x == head_q) || (x == tail_q);

	always_comb begin
		ex_status = ipq_pkg::STAT_IGNORED;
		ex_unlink = 1'b0;
		head_d    = head_q;
		tail_d    = tail_q;
		prev_req  = '0;
		next_req  = '0;

		prev_req.re    = accept;
		next_req.re    = accept;
		prev_req.raddr = req.node_id;
		if (req.func == ipq_pkg::FN_POP_HEAD) begin
			prev_req.raddr = head_q[ipq_pkg::ID_W-1:0];
		end else if (req.func == ipq_pkg::FN_POP_TAIL) begin
			prev_req.raddr = tail_q[ipq_pkg::ID_W-1:0];
		end
		next_req.raddr = prev_req.raddr;

		unique case (state_q)
			ST_CLEAR: begin
				prev_req.we    = 1'b1;
				prev_req.waddr = clr_cnt_q;
				prev_req.wdata = ipq_pkg::NIL_LINK;
				next_req.we    = 1'b1;
				next_req.waddr = clr_cnt_q;
				next_req.wdata = ipq_pkg::NIL_LINK;
			end
			ST_IDLE: begin
			end
			ST_EXEC: begin
				priority if (func_s1 == ipq_pkg::FN_PICK || is_pop) begin
					priority if (is_pop && !ipq_pkg::in_pool(x)) begin
						ex_status = ipq_pkg::STAT_EMPTY;
					end else if (!ipq_pkg::in_pool(x)) begin
						ex_status = ipq_pkg::STAT_IGNORED;
					end else if (p == ipq_pkg::NIL_LINK && n == ipq_pkg::NIL_LINK &&
					             !(x == head_q && x == tail_q)) begin
						ex_status = ipq_pkg::STAT_IGNORED;
					end else begin
						ex_status = ipq_pkg::STAT_DONE;
						ex_unlink = 1'b1;
						if (ipq_pkg::in_pool(p)) begin
							next_req.we    = 1'b1;
							next_req.waddr = p[ipq_pkg::ID_W-1:0];
							next_req.wdata = n;
						end else begin
							tail_d = n;
						end
						if (ipq_pkg::in_pool(n)) begin
							prev_req.we    = 1'b1;
							prev_req.waddr = n[ipq_pkg::ID_W-1:0];
							prev_req.wdata = p;
						end else begin
							head_d = p;
						end
					end
				end else if (func_s1 == ipq_pkg::FN_PUSH_HEAD) begin
					if (ipq_pkg::in_pool(x) && !linked) begin
						ex_status = ipq_pkg::STAT_DONE;
						if (ipq_pkg::in_pool(head_q)) begin
							next_req.we    = 1'b1;
							next_req.waddr = head_q[ipq_pkg::ID_W-1:0];
							next_req.wdata = x;
						end else begin
							tail_d = x;
						end
						prev_req.we    = 1'b1;
						prev_req.waddr = x[ipq_pkg::ID_W-1:0];
						prev_req.wdata = head_q;
						head_d         = x;
					end
				end else if (func_s1 == ipq_pkg::FN_PUSH_TAIL) begin
					if (ipq_pkg::in_pool(x) && !linked) begin
						ex_status = ipq_pkg::STAT_DONE;
						if (ipq_pkg::in_pool(tail_q)) begin
							prev_req.we    = 1'b1;
							prev_req.waddr = tail_q[ipq_pkg::ID_W-1:0];
							prev_req.wdata = x;
						end else begin
							head_d = x;
						end
						next_req.we    = 1'b1;
						next_req.waddr = x[ipq_pkg::ID_W-1:0];
						next_req.wdata = tail_q;
						tail_d         = x;
					end
				end else begin
					ex_status = ipq_pkg::STAT_IGNORED;
				end
			end
			ST_WB: begin
				if (wb_go && unlink_s2) begin
					prev_req.we    = 1'b1;
					prev_req.waddr = x[ipq_pkg::ID_W-1:0];
					prev_req.wdata = ipq_pkg::NIL_LINK;
					next_req.we    = 1'b1;
					next_req.waddr = x[ipq_pkg::ID_W-1:0];
					next_req.wdata = ipq_pkg::NIL_LINK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			head_q    <= ipq_pkg::NIL_LINK;
			tail_q    <= ipq_pkg::NIL_LINK;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					head_q  <= head_d;
					tail_q  <= tail_d;
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (wb_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= req.func;
			priority if (req.func == ipq_pkg::FN_POP_HEAD) begin
				node_s1 <= head_q;
			end else if (req.func == ipq_pkg::FN_POP_TAIL) begin
				node_s1 <= tail_q;
			end else begin
				node_s1 <= {1'b0, req.node_id};
			end
		end
		if (state_q == ST_EXEC) begin
			status_s2 <= ex_status;
			unlink_s2 <= ex_unlink;
			pop_s2    <= ex_unlink && is_pop;
		end
	end

	assign res_valid        = state_q == ST_WB;
	assign res.status       = status_s2;
	assign res.popped_node  = pop_s2 ? x[ipq_pkg::ID_W-1:0] : '0;
	assign res.popped_valid = pop_s2;
	assign res.now_empty    = !ipq_pkg::in_pool(head_q);

`ifndef SYNTHESIS
	a_exec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> ($past(state_q) == ST_IDLE && $past(req_valid)))
		else $error("link update started without an accepted transfer");

	a_ends_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (ipq_pkg::in_pool(head_q) == ipq_pkg::in_pool(tail_q)))
		else $error("head and tail disagree on whether the queue is empty");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!((prev_req.re && prev_req.we) || (next_req.re && next_req.we)))
		else $error("link memory read issued in a write cycle");

	a_pop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.popped_valid) |-> (res.status == ipq_pkg::STAT_DONE && unlink_s2))
		else $error("popped node reported without a completed unlink");
`endif

endmodule

// ===== hdl/indexed_pickable_queue.sv =====
// Top level of the indexed pickable queue: link memories, sequencer and the
// result output register. Depends on ipq_pkg, ipq_ram and ipq_ctrl.
//
// This block keeps a doubly linked queue over a pool of 1024 node indices.
// Each request transfer names an operation (pick a node out from anywhere,
// push at head, push at tail, pop head, pop tail) and a node, and yields
// exactly one response transfer with a status, the popped node and whether
// the queue is empty afterwards. The previous and next links live in two
// single-port-write RAMs with a registered read; head and tail are registers.
// After reset the block runs a clearing pass that writes null into every
// link entry, and holds req_stall high until it is done. Each operation
// then goes through a sequence: it issues the link read of the node,
// updates the neighbors' links and the head and tail, and last nulls the
// removed node's own links and hands the response to the output register.
// Requests are taken one at a time, so a read never meets a pending write
// to the same entry. A new request is accepted while an earlier response
// still waits in the output register; the last step of that request waits
// until the register is free.
module indexed_pickable_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ipq_pkg::ipq_in_t  req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ipq_pkg::ipq_out_t rsp
);

	ipq_pkg::ipq_mem_req_t      prev_req, next_req;
	logic [ipq_pkg::LINK_W-1:0] prev_rdata, next_rdata;
	logic                       res_valid;
	logic                       res_ready;
	ipq_pkg::ipq_out_t          res;
	logic                       rsp_valid_q;
	ipq_pkg::ipq_out_t          rsp_q;

	// The output register may take a new result when it is empty or its
	// content is being transferred in this cycle.
	assign res_ready = !rsp_valid_q || !rsp_stall;

	ipq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req        (req),
		.busy       (req_stall),
		.prev_req   (prev_req),
		.next_req   (next_req),
		.prev_rdata (prev_rdata),
		.next_rdata (next_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// Link toward the tail for each node.
	ipq_ram #(
		.WIDTH (ipq_pkg::LINK_W),
		.DEPTH (ipq_pkg::NODE_COUNT)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_req.we),
		.waddr (prev_req.waddr),
		.wdata (prev_req.wdata),
		.re    (prev_req.re),
		.raddr (prev_req.raddr),
		.rdata (prev_rdata)
	);

	// Link toward the head for each node.
	ipq_ram #(
		.WIDTH (ipq_pkg::LINK_W),
		.DEPTH (ipq_pkg::NODE_COUNT)
	) u_next_ram (
		.clk   (clk),
		.we    (next_req.we),
		.waddr (next_req.waddr),
		.wdata (next_req.wdata),
		.re    (next_req.re),
		.raddr (next_req.raddr),
		.rdata (next_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== bench/ipq_checker.sv =====
`timescale 1ns / 100ps
// Checker for the indexed pickable queue: watches both transfer channels,
// keeps its own copy of the link state and compares every response.
// Depends on ipq_pkg.
module ipq_checker
	import ipq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_stall,
	input  ipq_in_t  req,
	input  logic     rsp_valid,
	input  logic     rsp_stall,
	input  ipq_out_t rsp,
	output int       mismatches,
	output int       outstanding,
	output int       n_requests,
	output int       n_done,
	output int       n_ignored,
	output int       n_empty,
	output int       n_popped
);

	// Links toward the tail (prev) and toward the head (next), per node.
	logic [LINK_W-1:0] toward_tail [NODE_COUNT];
	logic [LINK_W-1:0] toward_head [NODE_COUNT];
	logic [LINK_W-1:0] head_ref;
	logic [LINK_W-1:0] tail_ref;

	ipq_out_t due_rsp [$];
	ipq_out_t forecast;
	int       rsp_seen;

	function automatic bit is_node(input logic [LINK_W-1:0] l);
		return int'(l) < NODE_COUNT;
	endfunction

	function automatic bit is_member(input logic [ID_W-1:0] x);
		return toward_tail[x] != NIL_LINK || toward_head[x] != NIL_LINK ||
			{1'b0, x} == head_ref || {1'b0, x} == tail_ref;
	endfunction

	// Take node x out of the queue; returns 0 when x was not in it.
	function automatic bit detach(input logic [ID_W-1:0] x);
		logic [LINK_W-1:0] p;
		logic [LINK_W-1:0] n;
		p = toward_tail[x];
		n = toward_head[x];
		if (p == NIL_LINK && n == NIL_LINK &&
			!({1'b0, x} == head_ref && {1'b0, x} == tail_ref))
			return 1'b0;
		if (is_node(p))
			toward_head[p[ID_W-1:0]] = n;
		else
			tail_ref = n;
		if (is_node(n))
			toward_tail[n[ID_W-1:0]] = p;
		else
			head_ref = p;
		toward_tail[x] = NIL_LINK;
		toward_head[x] = NIL_LINK;
		return 1'b1;
	endfunction

	function automatic ipq_out_t apply_link_op(input ipq_in_t op);
		ipq_out_t          res;
		logic [LINK_W-1:0] end_ref;
		logic [ID_W-1:0]   x;
		res = '0;
		res.status = STAT_IGNORED;
		x = op.node_id;
		case (op.func)
			FN_PICK: begin
				if (detach(x))
					res.status = STAT_DONE;
			end
			FN_PUSH_HEAD: begin
				if (!is_member(x)) begin
					if (is_node(head_ref))
						toward_head[head_ref[ID_W-1:0]] = {1'b0, x};
					else
						tail_ref = {1'b0, x};
					toward_tail[x] = head_ref;
					head_ref = {1'b0, x};
					res.status = STAT_DONE;
				end
			end
			FN_PUSH_TAIL: begin
				if (!is_member(x)) begin
					if (is_node(tail_ref))
						toward_tail[tail_ref[ID_W-1:0]] = {1'b0, x};
					else
						head_ref = {1'b0, x};
					toward_head[x] = tail_ref;
					tail_ref = {1'b0, x};
					res.status = STAT_DONE;
				end
			end
			FN_POP_HEAD, FN_POP_TAIL: begin
				end_ref = (op.func == FN_POP_HEAD) ? head_ref : tail_ref;
				if (!is_node(end_ref)) begin
					res.status = STAT_EMPTY;
				end else if (detach(end_ref[ID_W-1:0])) begin
					res.status       = STAT_DONE;
					res.popped_node  = end_ref[ID_W-1:0];
					res.popped_valid = 1'b1;
				end
			end
			default: ;
		endcase
		res.now_empty = !is_node(head_ref);
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t ns, response %0d: %s", $time, rsp_seen, msg);
		mismatches++;
	endtask

	task automatic check_rsp(input ipq_out_t got);
		ipq_out_t want;
		if (due_rsp.size() == 0) begin
			flag_mismatch($sformatf("response %h with no request waiting", got));
			return;
		end
		want = due_rsp.pop_front();
		if (got.status !== want.status)
			flag_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
		if (got.popped_node !== want.popped_node)
			flag_mismatch($sformatf("popped_node %0d, wanted %0d",
				got.popped_node, want.popped_node));
		if (got.popped_valid !== want.popped_valid)
			flag_mismatch($sformatf("popped_valid %b, wanted %b",
				got.popped_valid, want.popped_valid));
		if (got.now_empty !== want.now_empty)
			flag_mismatch($sformatf("now_empty %b, wanted %b",
				got.now_empty, want.now_empty));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODE_COUNT; i++) begin
				toward_tail[i] = NIL_LINK;
				toward_head[i] = NIL_LINK;
			end
			head_ref = NIL_LINK;
			tail_ref = NIL_LINK;
			due_rsp.delete();
			outstanding = 0;
			mismatches  = 0;
			n_requests  = 0;
			n_done      = 0;
			n_ignored   = 0;
			n_empty     = 0;
			n_popped    = 0;
			rsp_seen    = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				check_rsp(rsp);
				rsp_seen++;
			end
			if (req_valid && !req_stall) begin
				forecast = apply_link_op(req);
				due_rsp.push_back(forecast);
				n_requests++;
				case (forecast.status)
					STAT_DONE:    n_done++;
					STAT_IGNORED: n_ignored++;
					default:      n_empty++;
				endcase
				if (forecast.popped_valid)
					n_popped++;
			end
			outstanding = due_rsp.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Top of the bench for the indexed pickable queue: clock, reset, request and
// response-side stimulus, and the verdict. Depends on ipq_pkg, ipq_checker
// and the block itself.
module testbench;
	import ipq_pkg::*;

	// Function codes the block does not define; they must come back ignored.
	localparam logic [2:0] FN_SPARE_5 = 3'd5;
	localparam logic [2:0] FN_SPARE_6 = 3'd6;
	localparam logic [2:0] FN_SPARE_7 = 3'd7;

	localparam int RANDOM_PER_PHASE = 340;
	localparam int PRESSURE_ITEMS   = 40;
	localparam int HOLD_OFF_CYCLES  = 250;
	localparam int DRAIN_CYCLES     = 8;
	// Clearing pass, then every item at its slowest with both sides idling hard.
	localparam int CYCLE_LIMIT      = 400000;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	ipq_in_t  req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	ipq_out_t rsp;

	int mismatches;
	int outstanding;
	int n_requests;
	int n_done;
	int n_ignored;
	int n_empty;
	int n_popped;

	// Idle rates in percent for each side, and the request for the one long
	// receiver hold-off.
	int snd_idle    = 0;
	int rcv_idle    = 0;
	bit hold_armed  = 1'b0;
	int cycle_count = 0;

	// The directed items that open the run.
	ipq_in_t opening [$];

	indexed_pickable_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	ipq_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.n_requests  (n_requests),
		.n_done      (n_done),
		.n_ignored   (n_ignored),
		.n_empty     (n_empty),
		.n_popped    (n_popped)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Random operation. Most node indices come from a small window so that
	// pushes and picks keep finding nodes both inside and outside the queue;
	// the rest range over the whole pool. Pops are frequent enough that the
	// queue also drains to empty now and then.
	function automatic ipq_in_t random_op();
		ipq_in_t op;
		int      r;
		r = $urandom_range(0, 99);
		if (r < 22)
			op.func = FN_PUSH_HEAD;
		else if (r < 44)
			op.func = FN_PUSH_TAIL;
		else if (r < 62)
			op.func = FN_PICK;
		else if (r < 77)
			op.func = FN_POP_HEAD;
		else if (r < 93)
			op.func = FN_POP_TAIL;
		else begin
			case ($urandom_range(0, 2))
				0:       op.func = FN_SPARE_5;
				1:       op.func = FN_SPARE_6;
				default: op.func = FN_SPARE_7;
			endcase
		end
		if ($urandom_range(0, 99) < 85)
			op.node_id = ID_W'($urandom_range(0, 23));
		else
			op.node_id = ID_W'($urandom_range(0, NODE_COUNT - 1));
		return op;
	endfunction

	function automatic ipq_in_t make_op(input logic [2:0] f, input int n);
		ipq_in_t op;
		op.func    = f;
		op.node_id = ID_W'(n);
		return op;
	endfunction

	// Offer one item and return at the edge where the transfer happens.
	// Valid is left high, so back-to-back items need no extra edge.
	task automatic send_item(input ipq_in_t it);
		while ($urandom_range(0, 99) < snd_idle) begin
			req_valid <= 1'b0;
			req       <= ipq_in_t'($urandom);
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Receiver side. Once the hold-off is requested, the response channel
	// stalls without a break until the count kept here runs out; otherwise
	// the stall is drawn at the current rate.
	initial begin : receiver
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_used) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < rcv_idle);
			end
		end
	end

	// Watchdog: a hang anywhere, including a leftover expectation, ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d responses outstanding",
			cycle_count, outstanding);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		// Empty-queue pops, then a pick of a node that is not in the queue.
		opening.push_back(make_op(FN_POP_HEAD, 0));
		opening.push_back(make_op(FN_POP_TAIL, NODE_COUNT - 1));
		opening.push_back(make_op(FN_PICK, 5));
		// A sole member has null links but is still linked: a second push of
		// it is ignored, and a pick of it empties the queue.
		opening.push_back(make_op(FN_PUSH_HEAD, 0));
		opening.push_back(make_op(FN_PUSH_TAIL, 0));
		opening.push_back(make_op(FN_PICK, 0));
		// Build 682, 0, 1023, 341 from head to tail with both pushes.
		opening.push_back(make_op(FN_PUSH_TAIL, NODE_COUNT - 1));
		opening.push_back(make_op(FN_PUSH_HEAD, 0));
		opening.push_back(make_op(FN_PUSH_TAIL, 341));
		opening.push_back(make_op(FN_PUSH_HEAD, 682));
		opening.push_back(make_op(FN_PUSH_HEAD, NODE_COUNT - 1));
		opening.push_back(make_op(FN_PUSH_TAIL, 341));
		// Picks from the middle, the head and the tail.
		opening.push_back(make_op(FN_PICK, NODE_COUNT - 1));
		opening.push_back(make_op(FN_PICK, 682));
		opening.push_back(make_op(FN_PICK, 341));
		opening.push_back(make_op(FN_PICK, 341));
		// Undefined function codes change nothing.
		opening.push_back(make_op(FN_SPARE_5, 7));
		opening.push_back(make_op(FN_SPARE_6, 0));
		opening.push_back(make_op(FN_SPARE_7, NODE_COUNT - 1));
		// Pops of a real node from each end, then pops down to empty.
		opening.push_back(make_op(FN_PUSH_TAIL, 7));
		opening.push_back(make_op(FN_PUSH_TAIL, 8));
		opening.push_back(make_op(FN_POP_HEAD, 0));
		opening.push_back(make_op(FN_POP_TAIL, 0));
		opening.push_back(make_op(FN_POP_TAIL, 0));
		opening.push_back(make_op(FN_POP_HEAD, 0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// First phase: the sender idles less than the receiver stalls.
		snd_idle = 23;
		rcv_idle = 45;
		foreach (opening[i])
			send_item(opening[i]);
		repeat (RANDOM_PER_PHASE) send_item(random_op());

		// Second phase: the other way round.
		snd_idle = 45;
		rcv_idle = 23;
		repeat (RANDOM_PER_PHASE) send_item(random_op());

		// Last phase: neither side idles. It opens with a long receiver
		// hold-off while requests keep coming, so the block backs up and
		// stalls its request channel.
		snd_idle   = 0;
		rcv_idle   = 0;
		hold_armed = 1'b1;
		repeat (PRESSURE_ITEMS) send_item(random_op());
		repeat (RANDOM_PER_PHASE - PRESSURE_ITEMS) send_item(random_op());
		req_valid <= 1'b0;

		// One edge first, so the count already holds the last request.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests: %0d done, %0d ignored, %0d pops on empty.",
			n_requests, n_done, n_ignored, n_empty);
		$display("It popped %0d nodes and held the response side off for %0d cycles once.",
			n_popped, HOLD_OFF_CYCLES);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/ipq_pkg.sv
hdl/ipq_ram.sv
hdl/ipq_ctrl.sv
hdl/indexed_pickable_queue.sv
bench/ipq_checker.sv
bench/testbench.sv
